>>> rtl/core/wmd_pkg.sv
`default_nettype none
package wmd_pkg;

	// defaults for the top level parameters
	localparam int PREVIEW_POINTS_DEF = 1024;
	localparam int SAMPLE_BITS_DEF    = 16;

	// fixed geometry
	localparam int MIN_POINTS  = 64;
	localparam int MAX_RESULTS = 64;
	localparam int TOTAL_W     = 31;
	localparam int CHAN_W      = 2;
	localparam int INDEX_W     = 16;
	localparam int CFG_IDX_W   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN  = 2'd1;

	// channel codes
	localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MONO,
		ST_MIN,
		ST_MAX,
		ST_CHECK,
		ST_BUMP,
		ST_LOOK,
		ST_EMIT,
		ST_ADV
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MONO,
		OP_MIN,
		OP_MAX,
		OP_CMP,
		OP_BUMP,
		OP_ADV,
		OP_INIT
	} alu_op_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic out_ready;
		logic restart;
		logic skip;
		logic close;
		logic more;
	} stat_t;

	// controls from sequencer to datapath
	typedef struct packed {
		alu_op_t op;
		logic    in_ready;
		logic    out_valid;
		logic    load_in;
		logic    mono;
		logic    fold_min;
		logic    fold_max;
		logic    capture;
		logic    bump;
		logic    look;
		logic    adv;
		logic    init;
	} ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/wmd_alu.sv
`default_nettype none
module wmd_alu #(
	parameter int WIDTH = 33
) (
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	input  wire logic             sub,
	output logic      [WIDTH-1:0] res
);

	// shared adder, subtract as a plus inverted b plus one
	logic [WIDTH-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign res   = a + b_eff + {{(WIDTH-1){1'b0}}, sub};

endmodule
`default_nettype wire

>>> rtl/core/wmd_fsm.sv
`default_nettype none
module wmd_fsm (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wmd_pkg::stat_t stat,
	output wmd_pkg::ctrl_t      ctrl
);
	import wmd_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:  state_d = ST_IDLE;
			ST_IDLE:  if (stat.in_valid) state_d = ST_MONO;
			ST_MONO:  state_d = stat.skip ? ST_IDLE : ST_MIN;
			ST_MIN:   state_d = ST_MAX;
			ST_MAX:   state_d = ST_CHECK;
			ST_CHECK: state_d = stat.close ? ST_BUMP : ST_ADV;
			ST_BUMP:  state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_ready) state_d = stat.more ? ST_BUMP : ST_ADV;
			end
			ST_ADV:   state_d = ST_IDLE;
			default:  state_d = ST_INIT;
		endcase
		// a total or channel register write restarts the pass
		if (stat.restart) state_d = ST_INIT;
	end

	// outputs
	always_comb begin
		ctrl = '0;
		ctrl.op = OP_NONE;
		case (state_q)
			ST_INIT: begin
				ctrl.op   = OP_INIT;
				ctrl.init = 1'b1;
			end
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load_in  = stat.in_valid;
			end
			ST_MONO: begin
				ctrl.op   = OP_MONO;
				ctrl.mono = 1'b1;
			end
			ST_MIN: begin
				ctrl.op       = OP_MIN;
				ctrl.fold_min = 1'b1;
			end
			ST_MAX: begin
				ctrl.op       = OP_MAX;
				ctrl.fold_max = 1'b1;
			end
			ST_CHECK: begin
				ctrl.op      = OP_CMP;
				ctrl.capture = stat.close;
			end
			ST_BUMP: begin
				ctrl.op   = OP_BUMP;
				ctrl.bump = 1'b1;
			end
			ST_LOOK: begin
				ctrl.op   = OP_CMP;
				ctrl.look = 1'b1;
			end
			ST_EMIT: begin
				ctrl.out_valid = 1'b1;
				ctrl.capture   = stat.out_ready && stat.more;
			end
			ST_ADV: begin
				ctrl.op  = OP_ADV;
				ctrl.adv = 1'b1;
			end
			default: ctrl = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/waveform_minmax_decimator.sv
// a frame is accepted in idle, then takes the mono, min fold, max fold and close check
// steps, plus a boundary add, look-ahead compare and output per point it closes, the
// output waiting for out_ready; an advance step ends the frame, and a new frame is taken
// only in idle; a frame past the end or with no points left ends after the mono step
// every arithmetic step uses one shared adder/subtractor under a small sequencer
// reset is asynchronous active low; setup runs after reset and total/channel writes
`default_nettype none
module waveform_minmax_decimator #(
	parameter int PREVIEW_POINTS = wmd_pkg::PREVIEW_POINTS_DEF,
	parameter int SAMPLE_BITS    = wmd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [wmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wmd_pkg::TOTAL_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [wmd_pkg::INDEX_W-1:0]        point_index,
	output logic signed [SAMPLE_BITS-1:0]      min_level,
	output logic signed [SAMPLE_BITS-1:0]      max_level,
	output logic                               last_in_run
);
	import wmd_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int PCNT_W = $clog2(PREVIEW_POINTS + 1);
	localparam int SUM_W  = TOTAL_W + PCNT_W;
	localparam int AW     = SUM_W + 1;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	localparam logic [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

	// configuration
	logic [TOTAL_W-1:0] total_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               restart;

	// pass state
	logic [TOTAL_W-1:0] sc_q;
	logic [PCNT_W-1:0]  pc_q;
	logic [CNT_W-1:0]   count_q;
	logic [SB-1:0]      min_q;
	logic [SB-1:0]      max_q;
	logic [SUM_W-1:0]   pbs_q;
	logic [SUM_W-1:0]   thr_q;

	// frame and result holding
	logic [SB-1:0]      left_q;
	logic [SB-1:0]      right_q;
	logic [SB-1:0]      mono_q;
	logic [INDEX_W-1:0] idx_q;
	logic [SB-1:0]      omin_q;
	logic [SB-1:0]      omax_q;
	logic               last_q;
	logic               more_q;

	// derived point count and span
	logic [TOTAL_W-1:0] pts_floor;
	logic [TOTAL_W-1:0] pts_full;
	logic [PCNT_W-1:0]  p_w;
	logic [PCNT_W-1:0]  span_w;

	logic [AW-1:0]      alu_a;
	logic [AW-1:0]      alu_b;
	logic               alu_sub;
	logic [AW-1:0]      alu_res;
	logic               alu_neg;
	logic               close;
	logic               skip;
	logic [SB-1:0]      mono_w;
	logic [INDEX_W+PCNT_W-1:0] idx_full;

	stat_t stat;
	ctrl_t ctrl;

	assign restart = cfg_we && ((cfg_index == REG_TOTAL) || (cfg_index == REG_CHAN));

	// point count: min(PREVIEW_POINTS, max(64, n)), zero for an empty sample
	always_comb begin
		pts_floor = (total_q > TOTAL_W'(MIN_POINTS)) ? total_q : TOTAL_W'(MIN_POINTS);
		pts_full  = (pts_floor > TOTAL_W'(PREVIEW_POINTS)) ? TOTAL_W'(PREVIEW_POINTS)
			: pts_floor;
		p_w       = (total_q == '0) ? '0 : pts_full[PCNT_W-1:0];
		span_w    = (total_q < {{(TOTAL_W-PCNT_W){1'b0}}, p_w}) ? total_q[PCNT_W-1:0] : p_w;
	end

	// operand select for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (ctrl.op)
			OP_MONO: begin
				alu_a = {{(AW-SB){left_q[SB-1]}}, left_q};
				alu_b = {{(AW-SB){right_q[SB-1]}}, right_q};
			end
			OP_MIN: begin
				alu_a   = {{(AW-SB){mono_q[SB-1]}}, mono_q};
				alu_b   = {{(AW-SB){min_q[SB-1]}}, min_q};
				alu_sub = 1'b1;
			end
			OP_MAX: begin
				alu_a   = {{(AW-SB){max_q[SB-1]}}, max_q};
				alu_b   = {{(AW-SB){mono_q[SB-1]}}, mono_q};
				alu_sub = 1'b1;
			end
			OP_CMP: begin
				alu_a   = {1'b0, pbs_q};
				alu_b   = {1'b0, thr_q};
				alu_sub = 1'b1;
			end
			OP_BUMP: begin
				alu_a = {1'b0, pbs_q};
				alu_b = {{(AW-TOTAL_W){1'b0}}, total_q};
			end
			OP_ADV: begin
				alu_a = {1'b0, thr_q};
				alu_b = {{(AW-PCNT_W){1'b0}}, p_w};
			end
			OP_INIT: begin
				alu_a = {{(AW-PCNT_W){1'b0}}, p_w};
				alu_b = {{(AW-PCNT_W){1'b0}}, span_w};
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	wmd_alu #(
		.WIDTH(AW)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sub(alu_sub),
		.res(alu_res)
	);

	assign alu_neg = alu_res[AW-1];

	// mono level: left alone, or floor of half the sum
	assign mono_w = (chan_q == CHAN_MONO) ? left_q : alu_res[SB:1];

	// bucket closes if point edge < sample edge + span, within point and result limits
	assign close = alu_neg && (pc_q < p_w) && (count_q < CNT_W'(MAX_RESULTS));
	assign skip  = (p_w == '0) || (sc_q >= total_q) || (pc_q >= p_w);

	assign idx_full = {{INDEX_W{1'b0}}, pc_q};

	always_comb begin
		stat.in_valid  = in_valid;
		stat.out_ready = out_ready;
		stat.restart   = restart;
		stat.skip      = skip;
		stat.close     = close;
		stat.more      = more_q;
	end

	wmd_fsm u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			chan_q  <= CHAN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_TOTAL) total_q <= cfg_data;
			if (cfg_index == REG_CHAN)  chan_q  <= cfg_data[CHAN_W-1:0];
		end
	end

	// pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q    <= '0;
			pc_q    <= '0;
			count_q <= '0;
			min_q   <= FULL_POS;
			max_q   <= FULL_NEG;
			pbs_q   <= '0;
			thr_q   <= '0;
			last_q  <= 1'b0;
			more_q  <= 1'b0;
		end else begin
			if (ctrl.init) begin
				sc_q  <= '0;
				pc_q  <= '0;
				min_q <= FULL_POS;
				max_q <= FULL_NEG;
				pbs_q <= {{(SUM_W-TOTAL_W){1'b0}}, total_q};
				thr_q <= alu_res[SUM_W-1:0];
			end
			if (ctrl.load_in) count_q <= '0;
			if (ctrl.fold_min && alu_neg) min_q <= mono_q;
			if (ctrl.fold_max && alu_neg) max_q <= mono_q;
			if (ctrl.capture) begin
				pc_q    <= pc_q + PCNT_W'(1);
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.bump) pbs_q <= alu_res[SUM_W-1:0];
			if (ctrl.look) begin
				last_q <= !close;
				more_q <= close;
			end
			// frame done: advance sample boundary, clear extremes after a close
			if (ctrl.adv) begin
				sc_q  <= sc_q + TOTAL_W'(1);
				thr_q <= alu_res[SUM_W-1:0];
				if (count_q != '0) begin
					min_q <= FULL_POS;
					max_q <= FULL_NEG;
				end
			end
		end
	end

	// frame and result payload
	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			left_q  <= left_sample;
			right_q <= right_sample;
		end
		if (ctrl.mono) mono_q <= mono_w;
		if (ctrl.capture) begin
			idx_q  <= idx_full[INDEX_W-1:0];
			omin_q <= min_q;
			omax_q <= max_q;
		end
	end

	assign in_ready    = ctrl.in_ready;
	assign out_valid   = ctrl.out_valid;
	assign point_index = idx_q;
	assign min_level   = omin_q;
	assign max_level   = omax_q;
	assign last_in_run = last_q;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	// the point counter may exceed a new, smaller count until the setup cycle
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.init || (pc_q <= p_w))
		else $error("point counter beyond point count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RESULTS))
		else $error("too many results for one item");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_in_run && !restart |=> ctrl.adv)
		else $error("last result not followed by frame advance");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(min_level) <= $signed(max_level)))
		else $error("bucket minimum above maximum");

endmodule
`default_nettype wire

>>> tb/waveform_minmax_decimator_tb.sv
module waveform_minmax_decimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wmd_pkg::*;

	localparam int SB             = SAMPLE_BITS_DEF;
	localparam int RANDOM_FRAMES  = 440;
	localparam int SETTLE_CYCLES  = 16;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int IDLE_PCT       = 24;
	localparam int STEADY_PHASE   = 1;

	// register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// channel codes that fall back to the stereo average
	localparam logic [CHAN_W-1:0] CHAN_ODD_LO = 2'd0;
	localparam logic [CHAN_W-1:0] CHAN_ODD_HI = 2'd3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 31'h7FFF_FFFF;

	typedef logic signed [SB-1:0] level_t;

	localparam level_t LEVEL_MIN = 16'sh8000;
	localparam level_t LEVEL_MAX = 16'sh7FFF;

	typedef struct {
		logic [INDEX_W-1:0] idx;
		level_t             lo;
		level_t             hi;
		logic               last;
	} point_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TOTAL_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	level_t               left_sample;
	level_t               right_sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [INDEX_W-1:0]   point_index;
	level_t               min_level;
	level_t               max_level;
	logic                 last_in_run;

	waveform_minmax_decimator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_index  (point_index),
		.min_level    (min_level),
		.max_level    (max_level),
		.last_in_run  (last_in_run)
	);

	always #4 clk = ~clk;

	// predicted decimator state
	logic [TOTAL_W-1:0] cur_total;
	logic [CHAN_W-1:0]  cur_chan;
	longint unsigned    frames_seen;
	longint unsigned    buckets_closed;
	longint unsigned    bucket_edge;
	longint unsigned    frame_edge;
	level_t             lvl_lo;
	level_t             lvl_hi;

	point_t      pending_points[$];
	int unsigned frames_counted = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;

	function automatic longint unsigned bucket_total();
		longint unsigned pts;
		if (cur_total == 0)
			return 0;
		pts = (cur_total > MIN_POINTS) ? longint'(cur_total) : MIN_POINTS;
		if (pts > PREVIEW_POINTS_DEF)
			pts = PREVIEW_POINTS_DEF;
		return pts;
	endfunction

	function automatic void rewind_pass();
		frames_seen    = 0;
		buckets_closed = 0;
		lvl_lo         = LEVEL_MAX;
		lvl_hi         = LEVEL_MIN;
		bucket_edge    = cur_total;
		frame_edge     = bucket_total();
	endfunction

	// current bucket ends on this frame
	function automatic bit bucket_closes(int unsigned emitted);
		longint unsigned n;
		longint unsigned p;
		longint unsigned span;
		n = cur_total;
		p = bucket_total();
		span = (n < p) ? n : p;
		return emitted < MAX_RESULTS && buckets_closed < p && bucket_edge < frame_edge + span;
	endfunction

	// fold one frame into the running min/max, queue the points it closes
	function automatic bit fold_frame(level_t l, level_t r);
		longint unsigned n;
		longint unsigned p;
		int              lr_sum;
		level_t          mono;
		level_t          lo;
		level_t          hi;
		int unsigned     emitted;
		point_t          pt;
		n = cur_total;
		p = bucket_total();
		if (p == 0 || frames_seen >= n || buckets_closed >= p)
			return 1'b0;
		if (cur_chan == CHAN_MONO) begin
			mono = l;
		end else begin
			lr_sum = int'(l) + int'(r);
			mono = level_t'(lr_sum >>> 1);
		end
		lo = (mono < lvl_lo) ? mono : lvl_lo;
		hi = (mono > lvl_hi) ? mono : lvl_hi;
		emitted = 0;
		while (bucket_closes(emitted)) begin
			pt.idx = buckets_closed[INDEX_W-1:0];
			pt.lo  = lo;
			pt.hi  = hi;
			emitted++;
			buckets_closed++;
			bucket_edge += n;
			pt.last = !bucket_closes(emitted);
			pending_points.insert(pending_points.size(), pt);
		end
		if (emitted > 0) begin
			lvl_lo = LEVEL_MAX;
			lvl_hi = LEVEL_MIN;
		end else begin
			lvl_lo = lo;
			lvl_hi = hi;
		end
		frames_seen++;
		frame_edge += p;
		return 1'b1;
	endfunction

	function automatic level_t pick_level();
		level_t v;
		case ($urandom_range(7))
			0: v = LEVEL_MIN;
			1: v = LEVEL_MAX;
			2: v = level_t'(int'($urandom_range(6)) - 3);
			default: v = level_t'($urandom);
		endcase
		return v;
	endfunction

	// wait for all points, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOTAL_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_TOTAL) begin
			cur_total = data;
			rewind_pass();
		end else if (idx == REG_CHAN) begin
			cur_chan = data[CHAN_W-1:0];
			rewind_pass();
		end
	endtask

	// offer one frame item, with an optional gap in front
	task automatic send_frame(input level_t l, input level_t r);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 50);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (fold_frame(l, r))
			frames_counted++;
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// compare each point item with the oldest prediction
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t unexpected point: expected none actual index %0d min %0d max %0d",
					$time, point_index, min_level, max_level);
				mismatches++;
			end else begin
				want = pending_points.pop_front();
				check_field("point_index", want.idx, point_index);
				check_field("min_level", want.lo, min_level);
				check_field("max_level", want.hi, max_level);
				check_field("last_in_run", want.last, last_in_run);
			end
		end
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("waveform_minmax_decimator_tb failed");
			$finish;
		end
	end

	// zero length after reset: every frame is dropped
	task automatic test_empty_sample();
		send_frame(LEVEL_MIN, LEVEL_MAX);
		send_frame(LEVEL_MAX, LEVEL_MIN);
	endtask

	// one frame closes all 64 buckets, the next lies past the end
	task automatic test_single_frame();
		write_reg(REG_TOTAL, 31'd1);
		write_reg(REG_CHAN, TOTAL_W'(CHAN_MONO));
		send_frame(LEVEL_MIN, LEVEL_MAX);
		send_frame(LEVEL_MAX, LEVEL_MIN);
	endtask

	// stereo floor halving at the extremes and around zero
	task automatic test_stereo_floor();
		write_reg(REG_CHAN, TOTAL_W'(CHAN_RESET));
		write_reg(REG_TOTAL, 31'd8);
		send_frame(LEVEL_MAX, LEVEL_MAX);
		send_frame(LEVEL_MIN, LEVEL_MIN);
		send_frame(LEVEL_MIN, LEVEL_MAX);
		send_frame(LEVEL_MAX, LEVEL_MIN);
		send_frame(-16'sd1, 16'sd0);
		send_frame(16'sd1, 16'sd0);
		send_frame(-16'sd3, 16'sd0);
		send_frame(16'sh5555, 16'sh2AAA);
	endtask

	// codes 0 and 3 average like stereo; upper data bits are dropped
	task automatic test_odd_channel_codes();
		write_reg(REG_TOTAL, 31'd70);
		write_reg(REG_CHAN, {29'h1FFF_FFFF, CHAN_ODD_LO});
		send_frame(LEVEL_MIN, 16'sd5);
		send_frame(16'sd7, LEVEL_MAX);
		send_frame(-16'sd9, -16'sd2);
		write_reg(REG_CHAN, {29'd0, CHAN_ODD_HI});
		send_frame(LEVEL_MAX, 16'sd1);
		send_frame(-16'sd5, LEVEL_MIN);
		send_frame(16'sd100, -16'sd100);
	endtask

	// writes to undecoded indexes must not restart the pass
	task automatic test_unknown_index();
		write_reg(REG_CHAN, TOTAL_W'(CHAN_MONO));
		write_reg(REG_TOTAL, 31'd100);
		send_frame(16'sd10, LEVEL_MIN);
		send_frame(-16'sd20, LEVEL_MAX);
		send_frame(16'sd30, 16'sd0);
		write_reg(REG_SPARE_A, TOTAL_MAX);
		write_reg(REG_SPARE_B, 31'd0);
		send_frame(LEVEL_MIN, 16'sd0);
		send_frame(LEVEL_MAX, 16'sd0);
		send_frame(16'sd0, 16'sd0);
	endtask

	// largest length: the first bucket spans millions of frames
	task automatic test_huge_sample();
		write_reg(REG_TOTAL, TOTAL_MAX);
		send_frame(LEVEL_MIN, LEVEL_MIN);
		send_frame(LEVEL_MAX, LEVEL_MAX);
	endtask

	// random passes: mostly short samples, some long partial passes
	task automatic test_random_passes();
		int unsigned        start;
		int unsigned        phase;
		int unsigned        frames;
		logic [TOTAL_W-1:0] n;
		logic [TOTAL_W-1:0] chan_word;
		logic [CHAN_W-1:0]  ch;
		start = frames_counted;
		phase = 0;
		while (frames_counted - start < RANDOM_FRAMES) begin
			case ($urandom_range(19))
				0: n = '0;
				1: n = TOTAL_MAX;
				2, 3, 4: n = TOTAL_W'($urandom_range(1024, 4000));
				5, 6, 7, 8, 9: n = TOTAL_W'($urandom_range(64, 160));
				default: n = TOTAL_W'($urandom_range(1, 63));
			endcase
			case ($urandom_range(9))
				0: ch = CHAN_ODD_LO;
				1: ch = CHAN_ODD_HI;
				2, 3, 4, 5: ch = CHAN_MONO;
				default: ch = CHAN_RESET;
			endcase
			if (phase == STEADY_PHASE)
				n = TOTAL_W'($urandom_range(1100, 1400));
			chan_word = TOTAL_W'($urandom);
			if ($urandom_range(3) != 0)
				chan_word = '0;
			chan_word[CHAN_W-1:0] = ch;
			if ($urandom_range(1)) begin
				write_reg(REG_TOTAL, n);
				write_reg(REG_CHAN, chan_word);
			end else begin
				write_reg(REG_CHAN, chan_word);
				write_reg(REG_TOTAL, n);
			end
			if (n == 0 || n == TOTAL_MAX)
				frames = $urandom_range(2, 5);
			else if (n > PREVIEW_POINTS_DEF)
				frames = $urandom_range(20, 60);
			else
				frames = n + $urandom_range(0, 2);
			// one long stretch without any idling on either side
			if (phase == STEADY_PHASE) begin
				frames = 80;
				steady = 1'b1;
			end
			for (int i = 0; i < frames && frames_counted - start < RANDOM_FRAMES; i++) begin
				if (i == frames / 2 && $urandom_range(7) == 0)
					write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
						TOTAL_W'($urandom));
				send_frame(pick_level(), pick_level());
			end
			steady = 1'b0;
			phase++;
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_TOTAL;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		left_sample  <= '0;
		right_sample <= '0;
		cur_total = '0;
		cur_chan  = CHAN_RESET;
		rewind_pass();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_sample();
		test_single_frame();
		test_stereo_floor();
		test_odd_channel_codes();
		test_unknown_index();
		test_huge_sample();
		test_random_passes();
		settle();

		if (mismatches == 0) begin
			$display("waveform_minmax_decimator_tb passed");
		end else begin
			$display("waveform_minmax_decimator_tb failed");
		end
		$finish;
	end

endmodule
